// ----- src/uer_pkg.sv -----
`timescale 1ns / 1ps

package uer_pkg;

  // Field and register widths
  localparam int CNT_W      = 15;  // pulse width, elapsed counter
  localparam int DIST_W     = 19;
  localparam int CFG_W      = 22;
  localparam int TICK_W     = 6;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 40;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] MIN_DIST_RST = CFG_W'(20000);
  localparam logic [CFG_W-1:0] MAX_DIST_RST = CFG_W'(4000000);
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;

  // Register index, taken from paddr[2]
  localparam logic REG_MIN_DIST = 1'b0;
  localparam logic REG_MAX_DIST = 1'b1;

  // distance = floor(pulse * 500 / 29), done as pulse * RECIP_MULT >> RECIP_SHIFT
  localparam int DIST_SCALE  = 1000;
  localparam int CFG_SCALE   = 58;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 25;
  localparam int RECIP_MULT  = (500 * (1 << RECIP_SHIFT) + 28) / 29;
  localparam int DIST_MAX    = (1 << DIST_W) - 1;
  // smallest pulse whose distance no longer fits the field
  localparam int DIST_SAT_PULSE = ((DIST_MAX + 1) * 29 + 499) / 500;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_CLOSE    = 3'd1,
    ST_OUT_OF_RANGE = 3'd2,
    ST_TIMEOUT_HIGH = 3'd3,
    ST_TIMEOUT_LOW  = 3'd4
  } status_t;

  // What the sequencer hands to the range stage for one item
  typedef struct packed {
    logic             trig;
    logic             busy;
    logic             done;
    logic             measured;
    status_t          status;
    logic [CNT_W-1:0] pulse;
  } stage_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  pulse;
    logic [DIST_W-1:0] dist_um;
  } range_t;

endpackage

// ----- src/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps

// Ultrasonic echo ranger for an HC-SR04 style sensor. Each input transfer is
// either a one-microsecond tick carrying the sampled echo level (tuser = 0) or
// a start request (tuser = 1); every input transfer yields exactly one output
// transfer with the trigger level to drive, a busy flag, and, on the tick that
// ends a measurement, tuser = 1 with status, echo pulse width and distance in
// micrometres (floor(pulse*1000/58), saturated to the field). A start request
// while busy is ignored. The block takes one transfer per clock, every clock,
// as long as the output side keeps taking results. The sequencer state updates
// on acceptance, then a registered stage feeds the distance multiplier and
// limit compares ahead of the output register. Limits are set through the APB
// port (min at 0x0, max at 0x4) and should be written only while no
// measurement is in flight.
module ultrasonic_echo_ranger #(
  parameter int PRELOW_US  = 2,
  parameter int TRIGGER_US = 10,
  parameter int SETTLE_US  = 50,
  parameter int TIMEOUT_US = 30000
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [uer_pkg::S_TDATA_W-1:0]      s_tdata,   // [0] echo_level
  input  logic                               s_tuser,   // [0] req_type
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] trigger_level, [1] busy_res, [4:2] status, [19:5] pulse_width_us,
  // [38:20] distance_um
  output logic [uer_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                               m_tuser,   // [0] done_res
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [uer_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [uer_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [uer_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRELOW,
    PH_TRIG,
    PH_SETTLE,
    PH_WAITHI,
    PH_WAITLO
  } phase_t;

  localparam logic [TICK_W-1:0] PRELOW_V  = TICK_W'(PRELOW_US);
  localparam logic [TICK_W-1:0] TRIGGER_V = TICK_W'(TRIGGER_US);
  localparam logic [TICK_W-1:0] SETTLE_V  = TICK_W'(SETTLE_US);
  localparam logic [CNT_W-1:0]  TIMEOUT_V = CNT_W'(TIMEOUT_US);

  // configuration registers
  logic [CFG_W-1:0] min_distance_um;
  logic [CFG_W-1:0] max_distance_um;
  logic             cfg_write;

  // sequencer state
  phase_t           phase, phase_next;
  logic [TICK_W-1:0] phase_ticks, phase_ticks_next, ticks_inc;
  logic [CNT_W-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [CNT_W-1:0] echo_high, echo_high_next;
  logic             timed_out;

  // pipeline
  logic             s_accept;
  logic             stage_en, out_en;
  logic             stage_valid;
  stage_t           stage, stage_next;
  range_t           range;
  range_t           out_rng;
  logic             out_trig, out_busy, out_done;

  logic             req;
  logic             echo;

  assign req  = s_tuser;
  assign echo = s_tdata[0];

  // ---------------------------------------------------------------------------
  // APB: zero-wait writes and reads; paddr[2] picks the register
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance_um <= MIN_DIST_RST;
      max_distance_um <= MAX_DIST_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MAX_DIST) begin
        max_distance_um <= pwdata[CFG_W-1:0];
      end else begin
        min_distance_um <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_DIST) ? APB_DATA_W'(max_distance_um)
                                             : APB_DATA_W'(min_distance_um);

  // ---------------------------------------------------------------------------
  // Flow control: the output register drains first, the stage register moves
  // into it, and the input side follows whenever the stage register frees up.
  // ---------------------------------------------------------------------------
  assign out_en   = !m_tvalid || m_tready;
  assign stage_en = !stage_valid || out_en;
  assign s_tready = stage_en;
  assign s_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Sequencer: next state and per-item result for the item on the input
  // ---------------------------------------------------------------------------
  assign ticks_inc   = phase_ticks + TICK_W'(1);
  // the elapsed budget saturates rather than wrapping
  assign elapsed_inc = (elapsed == CNT_MAX) ? elapsed : elapsed + CNT_W'(1);
  assign timed_out   = elapsed_inc >= TIMEOUT_V;

  always_comb begin
    phase_next          = phase;
    phase_ticks_next    = phase_ticks;
    elapsed_next        = elapsed;
    echo_high_next      = echo_high;
    stage_next.done     = 1'b0;
    stage_next.measured = 1'b0;
    stage_next.status   = ST_OK;
    stage_next.pulse    = '0;

    if (req) begin
      // start only from idle; a start while busy is dropped
      if (phase == PH_IDLE) begin
        phase_next       = PH_PRELOW;
        phase_ticks_next = '0;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_PRELOW: begin
          phase_ticks_next = ticks_inc;
          if (ticks_inc >= PRELOW_V) begin
            phase_next       = PH_TRIG;
            phase_ticks_next = '0;
          end
        end
        PH_TRIG: begin
          phase_ticks_next = ticks_inc;
          if (ticks_inc >= TRIGGER_V) begin
            phase_ticks_next = '0;
            if (SETTLE_US == 0) begin
              // no settle time: start waiting for the echo right away
              phase_next     = PH_WAITHI;
              elapsed_next   = '0;
              echo_high_next = '0;
            end else begin
              phase_next = PH_SETTLE;
            end
          end
        end
        PH_SETTLE: begin
          phase_ticks_next = ticks_inc;
          if (ticks_inc >= SETTLE_V) begin
            phase_ticks_next = '0;
            phase_next       = PH_WAITHI;
            elapsed_next     = '0;
            echo_high_next   = '0;
          end
        end
        PH_WAITHI: begin
          elapsed_next = elapsed_inc;
          // the echo sample wins over the timeout on the same tick
          if (echo) begin
            phase_next     = PH_WAITLO;
            echo_high_next = CNT_W'(1);
          end else if (timed_out) begin
            stage_next.done   = 1'b1;
            stage_next.status = ST_TIMEOUT_HIGH;
          end
        end
        PH_WAITLO: begin
          elapsed_next = elapsed_inc;
          if (!echo) begin
            stage_next.done     = 1'b1;
            stage_next.measured = 1'b1;
            stage_next.pulse    = echo_high;
          end else if (timed_out) begin
            stage_next.done   = 1'b1;
            stage_next.status = ST_TIMEOUT_LOW;
          end else if (echo_high != CNT_MAX) begin
            echo_high_next = echo_high + CNT_W'(1);
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (stage_next.done) begin
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
      end
    end

    stage_next.trig = (phase_next == PH_TRIG);
    stage_next.busy = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_ticks <= '0;
      elapsed     <= '0;
      echo_high   <= '0;
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_accept) begin
        phase       <= phase_next;
        phase_ticks <= phase_ticks_next;
        elapsed     <= elapsed_next;
        echo_high   <= echo_high_next;
      end
      if (stage_en) begin
        stage_valid <= s_accept;
      end
      if (out_en) begin
        m_tvalid <= stage_valid;
      end
    end
  end

  // stage register: per-item sequencer result
  always_ff @(posedge clk) begin
    if (s_accept) begin
      stage <= stage_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Range stage: distance and limit classification, then the output register
  // ---------------------------------------------------------------------------
  uer_range_calc u_range_calc (
    .stage           (stage),
    .min_distance_um (min_distance_um),
    .max_distance_um (max_distance_um),
    .range           (range)
  );

  always_ff @(posedge clk) begin
    if (out_en && stage_valid) begin
      out_rng  <= range;
      out_trig <= stage.trig;
      out_busy <= stage.busy;
      out_done <= stage.done;
    end
  end

  assign m_tdata = {1'b0, out_rng.dist_um, out_rng.pulse, out_rng.status, out_busy, out_trig};
  assign m_tuser = out_done;

endmodule

// ----- src/uer_range_calc.sv -----
`timescale 1ns / 1ps

module uer_range_calc (
  input  uer_pkg::stage_t               stage,
  input  logic [uer_pkg::CFG_W-1:0]     min_distance_um,
  input  logic [uer_pkg::CFG_W-1:0]     max_distance_um,
  output uer_pkg::range_t               range
);
  import uer_pkg::*;

  localparam int PROD_W = RECIP_W + CNT_W;
  localparam int CMP_W  = CFG_W + 6;

  logic [PROD_W-1:0] dist_prod;
  logic [DIST_W-1:0] dist_sat;
  logic [CMP_W-1:0]  scaled;
  logic [CMP_W-1:0]  min_scaled;
  logic [CMP_W-1:0]  max_scaled;
  status_t           meas_status;

  assign dist_prod = PROD_W'(stage.pulse) * PROD_W'(RECIP_MULT);
  // saturate on the pulse itself, which is narrower than the product
  assign dist_sat = (stage.pulse >= CNT_W'(DIST_SAT_PULSE)) ? DIST_W'(DIST_MAX)
                                                            : dist_prod[RECIP_SHIFT +: DIST_W];

  // classify on the exact distance: compare pulse*1000 against limit*58
  assign scaled     = CMP_W'(stage.pulse) * CMP_W'(DIST_SCALE);
  assign min_scaled = CMP_W'(min_distance_um) * CMP_W'(CFG_SCALE);
  assign max_scaled = CMP_W'(max_distance_um) * CMP_W'(CFG_SCALE);

  always_comb begin
    priority if (scaled < min_scaled) begin
      meas_status = ST_TOO_CLOSE;
    end else if (scaled > max_scaled) begin
      meas_status = ST_OUT_OF_RANGE;
    end else begin
      meas_status = ST_OK;
    end
  end

  always_comb begin
    if (stage.measured) begin
      range.status  = meas_status;
      range.pulse   = stage.pulse;
      range.dist_um = dist_sat;
    end else begin
      range.status  = stage.status;
      range.pulse   = '0;
      range.dist_um = '0;
    end
  end

endmodule

// ----- src/uer_checker.sv -----
`timescale 1ns / 1ps

module uer_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [uer_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import uer_pkg::*;

  logic    trig, busy;
  status_t status;
  logic [CNT_W-1:0]  pulse;
  logic [DIST_W-1:0] dist_um;

  assign trig    = m_tdata[0];
  assign busy    = m_tdata[1];
  assign status  = status_t'(m_tdata[4:2]);
  assign pulse   = m_tdata[19:5];
  assign dist_um = m_tdata[38:20];

  // a result that ends nothing carries no measurement
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> status == ST_OK && pulse == '0 && dist_um == '0)
    else $error("result without done carries measurement fields");

  // a timeout reports no width and no distance
  a_timeout_no_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && (status == ST_TIMEOUT_HIGH || status == ST_TIMEOUT_LOW)
    |-> pulse == '0 && dist_um == '0)
    else $error("timeout result carries a pulse width or distance");

  // finishing a measurement returns the block to idle with trigger low
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !busy && !trig)
    else $error("done result still busy or triggering");

  // the trigger is only driven inside a sequence
  a_trig_in_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && trig |-> busy)
    else $error("trigger high while idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed or dropped");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/tb_ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int PRELOW_US  = 2;
  localparam int TRIGGER_US = 10;
  localparam int SETTLE_US  = 50;
  localparam int TIMEOUT_US = 30000;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     LONG_HOLD   = 100;
  localparam int     DRAIN_TAIL  = 10;

  localparam logic [APB_ADDR_W-1:0] ADDR_MIN_LIMIT = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LIMIT = 3'd4;
  localparam logic [CFG_W-1:0]      LIMIT_TOP      = '1;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Sequencer phases as the ranging predictor tracks them
  typedef enum logic [2:0] {
    RG_IDLE, RG_PRELOW, RG_TRIGGER, RG_SETTLE, RG_WAIT_HIGH, RG_WAIT_LOW
  } ranging_phase_t;

  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    status_t           status;
    logic [CNT_W-1:0]  pulse;
    logic [DIST_W-1:0] dist_um;
  } range_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state and its copy of the limit registers
  ranging_phase_t    rg_phase;
  logic [TICK_W-1:0] rg_ticks;
  logic [CNT_W-1:0]  rg_elapsed;
  logic [CNT_W-1:0]  rg_high_ticks;
  logic [CFG_W-1:0]  min_limit;
  logic [CFG_W-1:0]  max_limit;

  range_result_t pending_ranges[$];
  range_result_t oldest_range;

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_requests = 0;
  int     holds_served  = 0;
  int     hold_left     = 0;
  int     items_sent    = 0;
  int     mismatches    = 0;
  longint cycles        = 0;

  ultrasonic_echo_ranger #(
    .PRELOW_US  (PRELOW_US),
    .TRIGGER_US (TRIGGER_US),
    .SETTLE_US  (SETTLE_US),
    .TIMEOUT_US (TIMEOUT_US)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void report_mismatch(string what, longint unsigned want_v,
                                          longint unsigned got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want_v, got_v, cycles);
  endfunction

  // Exact status decision: compare scaled pulse against scaled limits, no rounding
  function automatic status_t classify_pulse(logic [CNT_W-1:0] pulse);
    longint unsigned scaled;
    scaled = 64'(pulse) * 64'd1000;
    if (scaled < 64'(min_limit) * 64'd58) return ST_TOO_CLOSE;
    if (scaled > 64'(max_limit) * 64'd58) return ST_OUT_OF_RANGE;
    return ST_OK;
  endfunction

  function automatic void begin_echo_wait();
    rg_phase      = RG_WAIT_HIGH;
    rg_elapsed    = '0;
    rg_high_ticks = '0;
  endfunction

  // Advance the ranging predictor by one accepted transfer and return its result
  function automatic range_result_t predict_ranging_result(logic req, logic echo);
    range_result_t   r;
    longint unsigned d;
    r = '0;
    if (req == REQ_START) begin
      // start while busy is dropped
      if (rg_phase == RG_IDLE) begin
        rg_phase = RG_PRELOW;
        rg_ticks = '0;
      end
    end else begin
      case (rg_phase)
        RG_PRELOW: begin
          rg_ticks = rg_ticks + 1'b1;
          if (rg_ticks >= PRELOW_US) begin
            rg_phase = RG_TRIGGER;
            rg_ticks = '0;
          end
        end
        RG_TRIGGER: begin
          rg_ticks = rg_ticks + 1'b1;
          if (rg_ticks >= TRIGGER_US) begin
            rg_ticks = '0;
            if (SETTLE_US == 0) begin_echo_wait();
            else rg_phase = RG_SETTLE;
          end
        end
        RG_SETTLE: begin
          rg_ticks = rg_ticks + 1'b1;
          if (rg_ticks >= SETTLE_US) begin
            rg_ticks = '0;
            begin_echo_wait();
          end
        end
        RG_WAIT_HIGH, RG_WAIT_LOW: begin
          // one budget covers both waits; the echo sample wins over the timeout
          if (rg_elapsed != CNT_MAX) rg_elapsed = rg_elapsed + 1'b1;
          if (rg_phase == RG_WAIT_HIGH) begin
            if (echo) begin
              rg_phase      = RG_WAIT_LOW;
              rg_high_ticks = CNT_W'(1);
            end else if (rg_elapsed >= TIMEOUT_US) begin
              r.done   = 1'b1;
              r.status = ST_TIMEOUT_HIGH;
            end
          end else begin
            if (!echo) begin
              r.done    = 1'b1;
              r.pulse   = rg_high_ticks;
              r.status  = classify_pulse(rg_high_ticks);
              d         = 64'(rg_high_ticks) * 64'd1000 / 64'd58;
              r.dist_um = (d > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(d);
            end else if (rg_elapsed >= TIMEOUT_US) begin
              r.done   = 1'b1;
              r.status = ST_TIMEOUT_LOW;
            end else if (rg_high_ticks != CNT_MAX) begin
              rg_high_ticks = rg_high_ticks + 1'b1;
            end
          end
          if (r.done) begin
            rg_phase = RG_IDLE;
            rg_ticks = '0;
          end
        end
        default: ;  // tick while idle: nothing moves
      endcase
    end
    r.trig = (rg_phase == RG_TRIGGER);
    r.busy = (rg_phase != RG_IDLE);
    return r;
  endfunction

  // Result checker: each output transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_ranges.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 1);
      end else begin
        oldest_range = pending_ranges.pop_front();
        if (m_tdata[0] !== oldest_range.trig)
          report_mismatch("trigger_level", oldest_range.trig, m_tdata[0]);
        if (m_tdata[1] !== oldest_range.busy)
          report_mismatch("busy_res", oldest_range.busy, m_tdata[1]);
        if (m_tuser !== oldest_range.done)
          report_mismatch("done_res", oldest_range.done, m_tuser);
        if (m_tdata[4:2] !== oldest_range.status)
          report_mismatch("status", oldest_range.status, m_tdata[4:2]);
        if (m_tdata[19:5] !== oldest_range.pulse)
          report_mismatch("pulse_width_us", oldest_range.pulse, m_tdata[19:5]);
        if (m_tdata[38:20] !== oldest_range.dist_um)
          report_mismatch("distance_um", oldest_range.dist_um, m_tdata[38:20]);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one transfer; entered and left at a falling edge. tvalid stays high on
  // exit so back-to-back transfers never drop it between items.
  task automatic send_item(logic req, logic echo);
    range_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {{(S_TDATA_W-1){1'b0}}, echo};
    do @(posedge clk); while (!s_tready);
    r = predict_ranging_result(req, echo);
    pending_ranges.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  // One tick, sometimes preceded by a start that lands while busy
  task automatic send_tick(logic echo, int stray_pct);
    if ($urandom_range(99) < stray_pct) send_item(REQ_START, 1'($urandom_range(1)));
    send_item(REQ_TICK, echo);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_ranges.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check_read(logic [APB_ADDR_W-1:0] addr, logic [CFG_W-1:0] want);
    logic [APB_DATA_W-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== APB_DATA_W'(want)) report_mismatch("register readback", want, got);
  endtask

  // Update both limits once the pipe is empty; the predictor copy follows
  task automatic set_limits(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    drain();
    apb_write(ADDR_MIN_LIMIT, APB_DATA_W'(lo));
    min_limit = lo;
    apb_write(ADDR_MAX_LIMIT, APB_DATA_W'(hi));
    max_limit = hi;
    apb_check_read(ADDR_MIN_LIMIT, lo);
    apb_check_read(ADDR_MAX_LIMIT, hi);
  endtask

  // Start, then tick through prelow, trigger and settle with a noisy echo
  task automatic start_and_settle(int stray_pct);
    send_item(REQ_START, 1'($urandom_range(1)));
    while (rg_phase inside {RG_PRELOW, RG_TRIGGER, RG_SETTLE})
      send_tick(1'($urandom_range(1)), stray_pct);
  endtask

  // Full well-formed measurement: echo rises after rise_delay ticks, stays high
  // for pulse_len ticks, then falls
  task automatic measure_echo(int rise_delay, int pulse_len, int stray_pct);
    start_and_settle(stray_pct);
    repeat (rise_delay) send_tick(1'b0, stray_pct);
    repeat (pulse_len) send_tick(1'b1, stray_pct);
    send_tick(1'b0, stray_pct);
  endtask

  task automatic test_reset_state();
    apb_check_read(ADDR_MIN_LIMIT, MIN_DIST_RST);
    apb_check_read(ADDR_MAX_LIMIT, MAX_DIST_RST);
    // ticks while idle give an all-zero result
    send_item(REQ_TICK, 1'b0);
    send_item(REQ_TICK, 1'b1);
  endtask

  task automatic test_default_measurement();
    measure_echo(0, 5, 30);     // too close under reset limits
    measure_echo(3, 1200, 0);   // ok under reset limits
  endtask

  task automatic test_limit_boundaries();
    // pulse 29 lands exactly on 500 um: neither too close nor out of range
    set_limits(22'd500, 22'd500);
    measure_echo(1, 28, 0);
    measure_echo(1, 29, 0);
    measure_echo(1, 30, 0);
    set_limits('0, LIMIT_TOP);
    measure_echo(0, 1, 0);
    set_limits(LIMIT_TOP, LIMIT_TOP);
    measure_echo(2, 40, 0);
    set_limits('0, '0);
    measure_echo(0, 1, 0);
  endtask

  task automatic test_timeouts();
    set_limits(22'd1000, LIMIT_TOP);
    // no echo at all: timeout waiting for high
    start_and_settle(0);
    while (rg_phase == RG_WAIT_HIGH) send_item(REQ_TICK, 1'b0);
    // echo rises on the very last tick of the budget, then falls: pulse of one
    start_and_settle(0);
    repeat (TIMEOUT_US - 1) send_item(REQ_TICK, 1'b0);
    send_item(REQ_TICK, 1'b1);
    send_item(REQ_TICK, 1'b0);
    // echo never falls: timeout waiting for low
    start_and_settle(0);
    while (rg_phase != RG_IDLE) send_item(REQ_TICK, 1'b1);
    // echo falls on the last tick of the budget: longest pulse
    start_and_settle(0);
    repeat (TIMEOUT_US - 1) send_item(REQ_TICK, 1'b1);
    send_item(REQ_TICK, 1'b0);
  endtask

  task automatic test_backpressure();
    // hold the result side while the sender keeps offering: input must stall
    hold_requests++;
    measure_echo(2, 20, 10);
    drain();
    repeat (3) send_item(REQ_TICK, 1'($urandom_range(1)));
    measure_echo(0, 3, 0);
    drain();
  endtask

  task automatic random_limits();
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    case ($urandom_range(3))
      0: begin
        lo = CFG_W'($urandom_range(0, 1500));
        hi = lo + CFG_W'($urandom_range(0, 2500));
      end
      1: begin
        lo = CFG_W'($urandom_range(0, 4194303));
        hi = CFG_W'($urandom_range(0, 4194303));
      end
      2: begin
        lo = '0;
        hi = LIMIT_TOP;
      end
      default: begin
        lo = MIN_DIST_RST;
        hi = MAX_DIST_RST;
      end
    endcase
    set_limits(lo, hi);
  endtask

  task automatic random_traffic(int n_items);
    int first;
    int rise;
    int pulse;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(99) < 80) begin
        rise  = ($urandom_range(9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 8);
        pulse = ($urandom_range(9) == 0) ? $urandom_range(41, 1500) : $urandom_range(1, 40);
        measure_echo(rise, pulse, 8);
      end else begin
        // noise: idle ticks with a random echo
        repeat ($urandom_range(1, 6)) send_item(REQ_TICK, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random();
    send_idle_pct = 7;
    recv_idle_pct = 72;
    random_limits();
    random_traffic(130);
    random_limits();
    random_traffic(130);
    send_idle_pct = 72;
    recv_idle_pct = 7;
    random_limits();
    random_traffic(130);
    random_limits();
    random_traffic(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_limits();
    random_traffic(130);
    random_limits();
    random_traffic(130);
  endtask

  initial begin
    rg_phase      = RG_IDLE;
    rg_ticks      = '0;
    rg_elapsed    = '0;
    rg_high_ticks = '0;
    min_limit     = MIN_DIST_RST;
    max_limit     = MAX_DIST_RST;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_reset_state();
    test_default_measurement();
    test_limit_boundaries();
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_timeouts();
    test_random();

    // let the last results come out, then a short tail for stray transfers
    drain();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- ultrasonic_echo_ranger.f -----
src/uer_pkg.sv
src/uer_range_calc.sv
src/ultrasonic_echo_ranger.sv
src/uer_checker.sv
tb/tb_ultrasonic_echo_ranger.sv
